FILE: hw/rtl/key_exchange_message_parser_defines.svh
// Assertion macros for the key-exchange message parser.
`ifndef KEY_EXCHANGE_MESSAGE_PARSER_DEFINES_SVH
`define KEY_EXCHANGE_MESSAGE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define KEMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define KEMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KEMP_ASSERT(lbl, prop, msg)
`define KEMP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/kemp_pkg.sv
// Shared constants and types for the key-exchange message parser.
`default_nettype none

package kemp_pkg;

  localparam int KEY_BYTES        = 32;
  localparam int ID_CAPACITY      = 16;
  localparam int ADDRESS_CAPACITY = 64;
  localparam int MASK_CAPACITY    = 16;

  localparam int KEY_CNT_W  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int ID_LEN_W   = $clog2(ID_CAPACITY + 1);
  localparam int ADDR_LEN_W = $clog2(ADDRESS_CAPACITY + 1);
  localparam int MASK_LEN_W = $clog2(MASK_CAPACITY + 1);

  localparam int BYTE_W      = 8;
  localparam int POS_W       = 6;
  localparam int KIND_W      = 2;
  localparam int STAT_W      = 3;
  localparam int OUT_TDATA_W = 24;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_FIELD_SEP = 1'b0;
  localparam logic REG_MASK_SEP  = 1'b1;

  localparam logic [BYTE_W-1:0] FIELD_SEP_RST = 8'd46;
  localparam logic [BYTE_W-1:0] MASK_SEP_RST  = 8'd47;
  localparam logic [BYTE_W-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE     = 8'h39;

  typedef enum logic [3:0] {
    PH_KEY  = 4'b0001,
    PH_ID   = 4'b0010,
    PH_ADDR = 4'b0100,
    PH_MASK = 4'b1000
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_KEY  = 2'd0,
    KIND_ID   = 2'd1,
    KIND_ADDR = 2'd2,
    KIND_MASK = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_ID    = 3'd1,
    ST_BAD_ADDR  = 3'd2,
    ST_BAD_MASK  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              dig;
    logic              fsep;
    logic              msep;
  } item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } qstat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kemp_front.sv
// Front stage: accepts input words and classifies each byte.
`default_nettype none

module kemp_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [kemp_pkg::BYTE_W-1:0]   in_tdata,   // data_byte
  input  wire logic                          in_tlast,   // end_of_message
  input  wire logic [kemp_pkg::BYTE_W-1:0]   field_sep,
  input  wire logic [kemp_pkg::BYTE_W-1:0]   mask_sep,
  output logic                               f_valid,
  input  wire logic                          f_ready,
  output kemp_pkg::item_t                    f_item
);
  import kemp_pkg::*;

  logic  f_valid_r, f_valid_nxt;
  item_t f_item_r, f_item_nxt;
  logic  accept;

  assign in_tready = !f_valid_r || f_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    f_item_nxt      = f_item_r;
    f_valid_nxt     = f_valid_r;
    if (accept) begin
      f_valid_nxt     = 1'b1;
      f_item_nxt.data = in_tdata;
      f_item_nxt.last = in_tlast;
      f_item_nxt.dig  = (in_tdata >= CHAR_ZERO) && (in_tdata <= CHAR_NINE);
      f_item_nxt.fsep = (in_tdata == field_sep);
      f_item_nxt.msep = (in_tdata == mask_sep);
    end else if (f_ready) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_item_r <= f_item_nxt;
  end

  assign f_valid = f_valid_r;
  assign f_item  = f_item_r;

endmodule

`default_nettype wire

FILE: hw/rtl/kemp_queue.sv
// Short queue of classified bytes between front and back.
`default_nettype none

module kemp_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  wire kemp_pkg::item_t wr_item,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output kemp_pkg::item_t rd_item,
  output kemp_pkg::qstat_t stat
);
  import kemp_pkg::*;

  item_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;

  assign wr_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item    = mem_r[rd_ptr_r];
  assign stat.count = cnt_r;
  assign stat.full  = !wr_ready;
  assign stat.empty = !rd_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/kemp_back.sv
// Back stage: field state machine, counters, error tracking, output register.
`default_nettype none

module kemp_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire kemp_pkg::item_t                q_item,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [kemp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [kemp_pkg::KIND_W-1:0]         out_tuser,
  output logic                                out_tlast
);
  import kemp_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [KEY_CNT_W-1:0]   key_cnt_r, key_cnt_nxt;
  logic [ID_LEN_W-1:0]    id_len_r, id_len_nxt;
  logic [ADDR_LEN_W-1:0]  addr_len_r, addr_len_nxt;
  logic [MASK_LEN_W-1:0]  mask_len_r, mask_len_nxt;
  status_t                err_r, err_nxt;

  logic                   pop;
  logic                   stored;
  logic [POS_W-1:0]       pos;
  kind_t                  kind;

  logic                   ov_r, ov_nxt;
  kind_t                  o_kind_r;
  logic [POS_W-1:0]       o_pos_r;
  logic [BYTE_W-1:0]      o_byte_r;
  logic                   o_stored_r;
  logic                   o_last_r;
  status_t                o_stat_r;

  assign q_ready = !ov_r || out_tready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    phase_nxt    = phase_r;
    key_cnt_nxt  = key_cnt_r;
    id_len_nxt   = id_len_r;
    addr_len_nxt = addr_len_r;
    mask_len_nxt = mask_len_r;
    err_nxt      = err_r;
    stored       = 1'b0;
    pos          = '0;

    case (phase_r)
      PH_KEY:  kind = KIND_KEY;
      PH_ID:   kind = KIND_ID;
      PH_ADDR: kind = KIND_ADDR;
      PH_MASK: kind = KIND_MASK;
      default: kind = KIND_KEY;
    endcase

    if (err_r == ST_OK) begin
      case (phase_r)
        PH_KEY: begin
          pos    = POS_W'(key_cnt_r);
          stored = 1'b1;
          if (key_cnt_r == KEY_CNT_W'(KEY_BYTES - 1)) begin
            phase_nxt = PH_ID;
          end else begin
            key_cnt_nxt = key_cnt_r + 1'b1;
          end
        end
        PH_ID: begin
          if (id_len_r >= ID_LEN_W'(ID_CAPACITY) || !(q_item.dig || q_item.fsep)) begin
            err_nxt = ST_BAD_ID;
          end else if (q_item.dig) begin
            pos        = POS_W'(id_len_r);
            stored     = 1'b1;
            id_len_nxt = id_len_r + 1'b1;
          end else begin
            phase_nxt = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (addr_len_r >= ADDR_LEN_W'(ADDRESS_CAPACITY) ||
              !(q_item.dig || q_item.fsep || q_item.msep)) begin
            err_nxt = ST_BAD_ADDR;
          end else if (q_item.dig || q_item.fsep) begin
            pos          = POS_W'(addr_len_r);
            stored       = 1'b1;
            addr_len_nxt = addr_len_r + 1'b1;
          end else begin
            phase_nxt = PH_MASK;
          end
        end
        PH_MASK: begin
          if (mask_len_r >= MASK_LEN_W'(MASK_CAPACITY) || !q_item.dig) begin
            err_nxt = ST_BAD_MASK;
          end else begin
            pos          = POS_W'(mask_len_r);
            stored       = 1'b1;
            mask_len_nxt = mask_len_r + 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_KEY;
        end
      endcase
    end

    // empty field check uses the counts after this byte
    if (q_item.last && err_nxt == ST_OK &&
        (id_len_nxt == '0 || addr_len_nxt == '0 || mask_len_nxt == '0)) begin
      err_nxt = ST_EMPTY;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (pop) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_KEY;
      key_cnt_r  <= '0;
      id_len_r   <= '0;
      addr_len_r <= '0;
      mask_len_r <= '0;
      err_r      <= ST_OK;
      ov_r       <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (pop) begin
        if (q_item.last) begin
          phase_r    <= PH_KEY;
          key_cnt_r  <= '0;
          id_len_r   <= '0;
          addr_len_r <= '0;
          mask_len_r <= '0;
          err_r      <= ST_OK;
        end else begin
          phase_r    <= phase_nxt;
          key_cnt_r  <= key_cnt_nxt;
          id_len_r   <= id_len_nxt;
          addr_len_r <= addr_len_nxt;
          mask_len_r <= mask_len_nxt;
          err_r      <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      o_kind_r   <= kind;
      o_pos_r    <= pos;
      o_byte_r   <= stored ? q_item.data : '0;
      o_stored_r <= stored;
      o_last_r   <= q_item.last;
      o_stat_r   <= err_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {(OUT_TDATA_W - POS_W - BYTE_W - 1 - STAT_W)'(0),
                       o_stat_r, o_stored_r, o_byte_r, o_pos_r};

endmodule

`default_nettype wire

FILE: hw/rtl/key_exchange_message_parser.sv
// Top level of the key-exchange message parser.
//
//   channel  | direction | tdata / data                          | tuser      | tlast
//   in_      | in        | [7:0] data_byte                       | -          | end_of_message
//   out_     | out       | [5:0] pos [13:6] byte [14] valid      | field_kind | message_done
//            |           | [17:15] status, [23:18] zero          |            |
//   cfg_     | APB       | 0x0 field_separator, 0x4 mask_sep     | -          | -
//
// One byte per cycle sustained while out_tready is high; the result passes through the classify
// register, the queue and the result register, in that order.
// The field state machine in the back stage updates once per byte and sets the rate.
// Reset is synchronous, active low; the separators return to '.' and '/'.
// Front and back stall independently; the four-entry queue absorbs the difference.
`default_nettype none

`include "key_exchange_message_parser_defines.svh"

module key_exchange_message_parser (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [kemp_pkg::BYTE_W-1:0]       in_tdata,    // [7:0] data_byte
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [kemp_pkg::OUT_TDATA_W-1:0]       out_tdata,   // [5:0] field_position,
                                                              // [13:6] stored_byte,
                                                              // [14] store_valid,
                                                              // [17:15] status
  output logic [kemp_pkg::KIND_W-1:0]            out_tuser,   // [1:0] field_kind
  output logic                                   out_tlast,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [kemp_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [kemp_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [kemp_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);
  import kemp_pkg::*;

  logic [BYTE_W-1:0] fsep_r, fsep_nxt;
  logic [BYTE_W-1:0] msep_r, msep_nxt;
  logic              cfg_wr;

  logic   f_valid, f_ready;
  item_t  f_item;
  logic   q_valid, q_ready;
  item_t  q_item;
  qstat_t q_stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    fsep_nxt = fsep_r;
    msep_nxt = msep_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_FIELD_SEP: fsep_nxt = cfg_pwdata[BYTE_W-1:0];
        REG_MASK_SEP:  msep_nxt = cfg_pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsep_r <= FIELD_SEP_RST;
      msep_r <= MASK_SEP_RST;
    end else begin
      fsep_r <= fsep_nxt;
      msep_r <= msep_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_FIELD_SEP: cfg_prdata = CFG_DATA_W'(fsep_r);
      REG_MASK_SEP:  cfg_prdata = CFG_DATA_W'(msep_r);
      default:       cfg_prdata = '0;
    endcase
  end

  kemp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .field_sep (fsep_r),
    .mask_sep  (msep_r),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_item    (f_item)
  );

  kemp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item),
    .stat     (q_stat)
  );

  kemp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `KEMP_ASSERT(a_stored_no_error, out_tvalid && out_tdata[14] |-> out_tdata[17:15] == ST_OK || out_tdata[17:15] == ST_EMPTY, "stored byte carries a field error")
  `KEMP_ASSERT(a_unstored_zero, out_tvalid && !out_tdata[14] |-> out_tdata[13:0] == '0, "unstored word has nonzero position or byte")
  `KEMP_ASSERT(a_queue_bound, q_stat.count <= QCNT_W'(QDEPTH) && !(q_stat.full && q_stat.empty), "queue occupancy out of range")

endmodule

`default_nettype wire

FILE: tb/key_exchange_message_parser_tb.sv
// Self-checking testbench for the key-exchange message parser: stream in, stream out, APB.
`timescale 1ns / 1ps

module key_exchange_message_parser_tb;
  import kemp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_FIELD_SEP = 3'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MASK_SEP  = 3'h4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int WORDS_PER_ROUND = 145;
  localparam int SEP_ROUNDS      = 6;
  localparam int HOLD_AT_WORD    = 600;
  localparam int HOLD_CYCLES     = 80;
  localparam logic [BYTE_W-1:0] FS_PLAN [SEP_ROUNDS] =
    '{8'd46, 8'h00, 8'hFF, "5", ".", "/"};
  localparam logic [BYTE_W-1:0] MS_PLAN [SEP_ROUNDS] =
    '{8'd47, 8'hFF, 8'h00, "/", ".", "3"};

  typedef struct {
    kind_t             kind;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data;
    logic              stored;
    logic              done;
    status_t           status;
  } parse_result_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    int                reps;
    logic              pinned;
    parse_result_t     want;
  } stim_row_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata    = '0;
  logic                   in_tlast    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // predictor state
  logic [BYTE_W-1:0] fsep_cfg = FIELD_SEP_RST;
  logic [BYTE_W-1:0] msep_cfg = MASK_SEP_RST;
  kind_t             cur_field = KIND_KEY;
  status_t           err_code  = ST_OK;
  int                key_cnt, id_len, addr_len, mask_len;

  parse_result_t     expected_q[$];
  parse_result_t     want;
  parse_result_t     no_pin;
  stim_row_t         script[$];
  logic [BYTE_W-1:0] message_bytes[$];
  logic              steady = 1'b0;
  int                fail_count = 0;
  int                words_sent = 0;
  int                results_seen = 0;
  int                messages = 0;
  int                cycle_count = 0;
  int                outcome_count[5] = '{0, 0, 0, 0, 0};

  key_exchange_message_parser u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [7:0] data_byte
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [5:0] field_position, [13:6] stored_byte,
                                // [14] store_valid, [17:15] status, [23:18] zero
    .out_tuser   (out_tuser),   // [1:0] field_kind
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic parse_result_t parse_byte(input logic [BYTE_W-1:0] b, input logic last);
    parse_result_t r;
    logic          dig;
    logic          is_fs;
    logic          is_ms;
    dig   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    is_fs = (b == fsep_cfg);
    is_ms = (b == msep_cfg);
    r.kind   = cur_field;
    r.pos    = '0;
    r.data   = '0;
    r.stored = 1'b0;
    r.done   = last;
    if (err_code == ST_OK) begin
      case (cur_field)
        KIND_KEY: begin
          r.pos    = POS_W'(key_cnt);
          r.stored = 1'b1;
          if (key_cnt + 1 >= KEY_BYTES) cur_field = KIND_ID;
          else key_cnt++;
        end
        KIND_ID: begin
          if (id_len >= ID_CAPACITY || !(dig || is_fs)) begin
            err_code = ST_BAD_ID;
          end else if (dig) begin
            r.pos    = POS_W'(id_len);
            r.stored = 1'b1;
            id_len++;
          end else begin
            cur_field = KIND_ADDR;
          end
        end
        KIND_ADDR: begin
          if (addr_len >= ADDRESS_CAPACITY || !(dig || is_fs || is_ms)) begin
            err_code = ST_BAD_ADDR;
          end else if (dig || is_fs) begin
            r.pos    = POS_W'(addr_len);
            r.stored = 1'b1;
            addr_len++;
          end else begin
            cur_field = KIND_MASK;
          end
        end
        default: begin
          if (mask_len >= MASK_CAPACITY || !dig) begin
            err_code = ST_BAD_MASK;
          end else begin
            r.pos    = POS_W'(mask_len);
            r.stored = 1'b1;
            mask_len++;
          end
        end
      endcase
    end
    if (last && err_code == ST_OK && (id_len == 0 || addr_len == 0 || mask_len == 0))
      err_code = ST_EMPTY;
    if (r.stored) r.data = b;
    r.status = err_code;
    if (last) begin
      cur_field = KIND_KEY;
      err_code  = ST_OK;
      key_cnt   = 0;
      id_len    = 0;
      addr_len  = 0;
      mask_len  = 0;
    end
    return r;
  endfunction

  function automatic void add_bytes(input logic [BYTE_W-1:0] b, input logic last,
                                    input int reps);
    stim_row_t row;
    row.data   = b;
    row.last   = last;
    row.reps   = reps;
    row.pinned = 1'b0;
    script.push_back(row);
  endfunction

  function automatic void add_pinned(input logic [BYTE_W-1:0] b, input logic last,
                                     input kind_t k, input int pos, input logic stored,
                                     input status_t s);
    stim_row_t row;
    row.data        = b;
    row.last        = last;
    row.reps        = 1;
    row.pinned      = 1'b1;
    row.want.kind   = k;
    row.want.pos    = POS_W'(pos);
    row.want.data   = stored ? b : '0;
    row.want.stored = stored;
    row.want.done   = last;
    row.want.status = s;
    script.push_back(row);
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_digit();
    return CHAR_ZERO + BYTE_W'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed messages; the rest overflow, leave a field empty,
  // carry a stray byte or stop early.
  function automatic void build_message();
    int id_n, addr_n, mask_n, flavor, cut, i;
    message_bytes.delete();
    flavor = $urandom_range(0, 99);
    id_n   = $urandom_range(1, ID_CAPACITY);
    addr_n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, ADDRESS_CAPACITY)
                                         : $urandom_range(1, 15);
    mask_n = $urandom_range(1, MASK_CAPACITY);
    if (flavor >= 66 && flavor < 76) begin
      case ($urandom_range(0, 2))
        0:       id_n   = ID_CAPACITY + $urandom_range(1, 3);
        1:       addr_n = ADDRESS_CAPACITY + $urandom_range(1, 2);
        default: mask_n = MASK_CAPACITY + $urandom_range(1, 3);
      endcase
    end else if (flavor >= 76 && flavor < 82) begin
      case ($urandom_range(0, 2))
        0:       id_n   = 0;
        1:       addr_n = 0;
        default: mask_n = 0;
      endcase
    end
    for (i = 0; i < KEY_BYTES; i++) message_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    for (i = 0; i < id_n; i++) message_bytes.push_back(rand_digit());
    message_bytes.push_back(fsep_cfg);
    for (i = 0; i < addr_n; i++)
      message_bytes.push_back(($urandom_range(0, 4) == 0) ? fsep_cfg : rand_digit());
    message_bytes.push_back(msep_cfg);
    for (i = 0; i < mask_n; i++) message_bytes.push_back(rand_digit());
    if (flavor >= 82 && flavor < 91) begin
      message_bytes[$urandom_range(KEY_BYTES, message_bytes.size() - 1)] =
        BYTE_W'($urandom_range(0, 255));
    end else if (flavor >= 91) begin
      cut = $urandom_range(1, message_bytes.size() - 1);
      while (message_bytes.size() > cut) void'(message_bytes.pop_back());
    end
  endfunction

  task automatic send_word(input logic [BYTE_W-1:0] b, input logic last, input logic pinned,
                           input parse_result_t pinned_want);
    int            gap;
    parse_result_t p;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    p = parse_byte(b, last);
    expected_q.push_back(pinned ? pinned_want : p);
    words_sent++;
    if (last) begin
      messages++;
      outcome_count[p.status]++;
    end
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_FIELD_SEP) fsep_cfg = value;
    else if (addr == ADDR_MASK_SEP) msep_cfg = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [CFG_ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DATA_W'(value)) begin
      $error("prdata at 0x%0h: expected %0d, got %0d", addr, value, cfg_prdata);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_separators(input logic [BYTE_W-1:0] fs, input logic [BYTE_W-1:0] ms);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write(ADDR_FIELD_SEP, fs);
    cfg_write(ADDR_MASK_SEP, ms);
    cfg_read(ADDR_FIELD_SEP, fs);
    cfg_read(ADDR_MASK_SEP, ms);
  endtask

  task automatic flag_mismatch(input string field, input int want_v, input int got_v);
    $error("%s: expected %0d, got %0d", field, want_v, got_v);
    fail_count++;
  endtask

  initial begin : stimulus
    int round;
    int words_in_round;
    int k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_read(ADDR_FIELD_SEP, FIELD_SEP_RST);
    cfg_read(ADDR_MASK_SEP, MASK_SEP_RST);

    // messages that end inside the key
    add_pinned(8'h00, 1'b1, KIND_KEY, 0, 1'b1, ST_EMPTY);
    add_pinned(8'hFF, 1'b1, KIND_KEY, 0, 1'b1, ST_EMPTY);
    // well-formed message
    add_bytes(8'hA5, 1'b0, KEY_BYTES - 1);
    add_pinned(8'h5A, 1'b0, KIND_KEY, KEY_BYTES - 1, 1'b1, ST_OK);
    add_pinned("0", 1'b0, KIND_ID, 0, 1'b1, ST_OK);
    add_pinned("9", 1'b0, KIND_ID, 1, 1'b1, ST_OK);
    add_pinned(".", 1'b0, KIND_ID, 0, 1'b0, ST_OK);
    add_pinned("1", 1'b0, KIND_ADDR, 0, 1'b1, ST_OK);
    add_pinned(".", 1'b0, KIND_ADDR, 1, 1'b1, ST_OK);
    add_pinned("/", 1'b0, KIND_ADDR, 0, 1'b0, ST_OK);
    add_pinned("2", 1'b0, KIND_MASK, 0, 1'b1, ST_OK);
    add_pinned("4", 1'b1, KIND_MASK, 1, 1'b1, ST_OK);
    // bad ID, sticky to the end
    add_bytes(8'h00, 1'b0, KEY_BYTES);
    add_pinned("A", 1'b0, KIND_ID, 0, 1'b0, ST_BAD_ID);
    add_pinned("3", 1'b1, KIND_ID, 0, 1'b0, ST_BAD_ID);
    // bad address
    add_bytes(8'hFF, 1'b0, KEY_BYTES);
    add_bytes("7", 1'b0, 1);
    add_bytes(".", 1'b0, 1);
    add_pinned(":", 1'b0, KIND_ADDR, 0, 1'b0, ST_BAD_ADDR);
    add_pinned("1", 1'b1, KIND_ADDR, 0, 1'b0, ST_BAD_ADDR);
    // bad netmask wins over the empty address
    add_bytes(8'h3C, 1'b0, KEY_BYTES);
    add_bytes("5", 1'b0, 1);
    add_bytes(".", 1'b0, 1);
    add_bytes("/", 1'b0, 1);
    add_pinned("x", 1'b0, KIND_MASK, 0, 1'b0, ST_BAD_MASK);
    add_pinned("8", 1'b1, KIND_MASK, 0, 1'b0, ST_BAD_MASK);
    // empty address flagged at the end
    add_bytes(8'h11, 1'b0, KEY_BYTES);
    add_bytes("6", 1'b0, 1);
    add_bytes(".", 1'b0, 1);
    add_bytes("/", 1'b0, 1);
    add_pinned("6", 1'b1, KIND_MASK, 0, 1'b1, ST_EMPTY);

    foreach (script[i])
      for (k = 0; k < script[i].reps; k++)
        send_word(script[i].data, script[i].last, script[i].pinned, script[i].want);

    for (round = 0; round < SEP_ROUNDS; round++) begin
      in_tvalid <= 1'b0;
      set_separators(FS_PLAN[round], MS_PLAN[round]);
      words_in_round = 0;
      while (words_in_round < WORDS_PER_ROUND) begin
        build_message();
        steady = ($urandom_range(0, 4) == 0);
        foreach (message_bytes[j])
          send_word(message_bytes[j], j == message_bytes.size() - 1, 1'b0, no_pin);
        words_in_round += message_bytes.size();
      end
    end
    in_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Parsed %0d words in %0d messages under %0d separator settings, %0d results.",
             words_sent, messages, SEP_ROUNDS + 1, results_seen);
    $display("Endings: ok %0d, bad id %0d, bad address %0d, bad netmask %0d, empty %0d",
             outcome_count[ST_OK], outcome_count[ST_BAD_ID], outcome_count[ST_BAD_ADDR],
             outcome_count[ST_BAD_MASK], outcome_count[ST_EMPTY]);
    if (fail_count == 0) $display("PASS key_exchange_message_parser");
    else $display("FAIL key_exchange_message_parser");
    $finish;
  end

  initial begin : result_sink
    int   span;
    int   r;
    logic held_off;
    held_off = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_off && words_sent >= HOLD_AT_WORD) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_tready <= 1'b1;
        span = $urandom_range(1, 30);
      end else if (r < 85) begin
        out_tready <= 1'b0;
        span = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_tready <= 1'b1;
        span = $urandom_range(50, 150);
      end else begin
        out_tready <= 1'b0;
        span = $urandom_range(10, 40);
      end
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_tuser !== want.kind) flag_mismatch("field_kind", want.kind, out_tuser);
        if (out_tdata[5:0] !== want.pos)
          flag_mismatch("field_position", want.pos, out_tdata[5:0]);
        if (out_tdata[13:6] !== want.data)
          flag_mismatch("stored_byte", want.data, out_tdata[13:6]);
        if (out_tdata[14] !== want.stored)
          flag_mismatch("store_valid", want.stored, out_tdata[14]);
        if (out_tdata[17:15] !== want.status)
          flag_mismatch("status", want.status, out_tdata[17:15]);
        if (out_tdata[23:18] !== '0) flag_mismatch("tdata pad", 0, out_tdata[23:18]);
        if (out_tlast !== want.done) flag_mismatch("message_done", want.done, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL key_exchange_message_parser");
      $finish;
    end
  end

endmodule
